/* hw/rtl/dtat_pkg.sv */
// Shared types and constants for the detection/track association table.
// Used by dtat_store and detection_track_association_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dtat_pkg;

	// Fixed field widths.
	localparam int ID_W    = 16;
	localparam int MISS_W  = 4;
	localparam int KIND_W  = 3;
	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	// Saturation value of an entry's miss counter.
	localparam logic [MISS_W-1:0] MISS_MAX = 4'd15;

	// Reset value of the miss limit register.
	localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 4'd2;

	// Input word commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_DETECT  = 2'd0,
		CMD_REFRESH = 2'd1,
		CMD_EOF     = 2'd2
	} cmd_t;

	// Result word kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_MATCHED  = 3'd0,
		KIND_ADDED    = 3'd1,
		KIND_DROPPED  = 3'd2,
		KIND_REFRESH  = 3'd3,
		KIND_BAD_SLOT = 3'd4,
		KIND_ENTRY    = 3'd5,
		KIND_EMPTY    = 3'd6
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT,
		ST_LIST
	} state_t;

	// Write enables of the two entry memories.
	typedef struct packed {
		logic box_we;
		logic meta_we;
	} wr_en_t;

endpackage

`default_nettype wire

/* hw/rtl/dtat_store.sv */
// Entry storage: a box memory and an id/miss memory, one write and one read port each.
// Reads are registered: the data for an address appears in the cycle after it. Depends on dtat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtat_store #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int BOX_W  = 48,
	parameter int META_W = 20
) (
	input  wire                   clk,
	input  dtat_pkg::wr_en_t      wr_en,
	input  wire  [ADDR_W-1:0]     waddr,
	input  wire  [BOX_W-1:0]      wbox,
	input  wire  [META_W-1:0]     wmeta,
	input  wire  [ADDR_W-1:0]     raddr,
	output logic [BOX_W-1:0]      rbox,
	output logic [META_W-1:0]     rmeta
);
	import dtat_pkg::*;

	logic [BOX_W-1:0]  box_mem  [DEPTH];
	logic [META_W-1:0] meta_mem [DEPTH];

	// Box memory: write port and registered read.
	always_ff @(posedge clk) begin
		if (wr_en.box_we) begin
			box_mem[waddr] <= wbox;
		end
		rbox <= box_mem[raddr];
	end

	// Id and miss memory: write port and registered read.
	always_ff @(posedge clk) begin
		if (wr_en.meta_we) begin
			meta_mem[waddr] <= wmeta;
		end
		rmeta <= meta_mem[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/detection_track_association_table.sv */
// Top level of the detection/track association table: sequencer, match test and result register.
// Depends on dtat_pkg and dtat_store.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  command, slot, box_x, box_y, box_w, box_h
//   out      output     out_valid / out_stall kind, object_id, match_count, out_x..out_h,
//                                            miss_count, live_count, last
//   cfg      input      cfg_wr_en            cfg_wr_data (miss limit)
//
// A detection reads the entry memory once per live entry, finishes the scan, loads the result
// and returns to idle before the next word is accepted. End of frame first runs the compaction
// pass; when any entry survives it then lists the survivors, one entry word per cycle while the
// output is not stalled, and else gives one empty result. A refresh loads its result directly.
// The memory read port is registered, so each entry is evaluated in the cycle after its read.
// arst_n clears the entry count, the next id and the linked flags, and sets the miss limit to 2.
// A new input word is taken only when the sequencer is idle; a stalled output holds its word
// and pauses the sequencer, but the input side may run one word ahead of a waiting result.
`timescale 1ns / 1ps
`default_nettype none

module detection_track_association_table #(
	parameter int MAX_ENTRIES = 16,
	parameter int COORD_BITS  = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// Configuration.
	input  wire                            cfg_wr_en,
	input  wire  [dtat_pkg::MISS_W-1:0]    cfg_wr_data,
	// Input channel.
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [dtat_pkg::CMD_W-1:0]     command,
	input  wire  [dtat_pkg::SLOT_W-1:0]    slot,
	input  wire  [COORD_BITS-1:0]          box_x,
	input  wire  [COORD_BITS-1:0]          box_y,
	input  wire  [COORD_BITS-1:0]          box_w,
	input  wire  [COORD_BITS-1:0]          box_h,
	// Output channel.
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [dtat_pkg::KIND_W-1:0]    kind,
	output logic [dtat_pkg::ID_W-1:0]      object_id,
	output logic [dtat_pkg::COUNT_W-1:0]   match_count,
	output logic [COORD_BITS-1:0]          out_x,
	output logic [COORD_BITS-1:0]          out_y,
	output logic [COORD_BITS-1:0]          out_w,
	output logic [COORD_BITS-1:0]          out_h,
	output logic [dtat_pkg::MISS_W-1:0]    miss_count,
	output logic [dtat_pkg::COUNT_W-1:0]   live_count,
	output logic                           last
);
	import dtat_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int EXT_W  = COORD_BITS + 1;
	localparam int BOX_W  = 4 * COORD_BITS;
	localparam int META_W = ID_W + MISS_W;

	// Control registers.
	state_t               state_q, state_d;
	cmd_t                 op_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     keep_q;
	logic [CNT_W-1:0]     match_q;
	logic [ID_W-1:0]      next_id_q;
	logic [MISS_W-1:0]    miss_limit_q;
	logic [MAX_ENTRIES-1:0] linked_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 rd_ok_q;

	// Detection word held for the whole operation.
	logic [COORD_BITS-1:0] dx_q, dy_q, dw_q, dh_q;
	logic [EXT_W-1:0]      dcx_q, dcy_q, dr_q, db_q;
	logic [SLOT_W-1:0]     slot_q;

	// Output register.
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ID_W-1:0]       object_id_q;
	logic [COUNT_W-1:0]    match_count_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q, out_w_q, out_h_q;
	logic [MISS_W-1:0]     miss_count_q;
	logic [COUNT_W-1:0]    live_count_q;
	logic                  last_q;

	// Memory interface.
	wr_en_t                wr_en;
	logic [IDX_W-1:0]      waddr, raddr;
	logic [BOX_W-1:0]      wbox, rbox;
	logic [META_W-1:0]     wmeta, rmeta;

	// Combinational control.
	logic                  in_acc, out_free;
	logic                  scan_issue, scan_done;
	logic                  det_hit, keep_hit;
	logic                  res_load, list_load;
	logic                  append, slot_ok, list_end;
	logic [CNT_W-1:0]      idx_next;
	logic [COORD_BITS-1:0] ex, ey, ew, eh;
	logic [EXT_W-1:0]      ecx, ecy, er, eb;
	logic                  det_in_ent, ent_in_det;
	logic [MISS_W-1:0]     rmiss, mnew;
	logic [ID_W-1:0]       rid;

	dtat_store #(
		.DEPTH  (MAX_ENTRIES),
		.ADDR_W (IDX_W),
		.BOX_W  (BOX_W),
		.META_W (META_W)
	) u_store (
		.clk   (clk),
		.wr_en (wr_en),
		.waddr (waddr),
		.wbox  (wbox),
		.wmeta (wmeta),
		.raddr (raddr),
		.rbox  (rbox),
		.rmeta (rmeta)
	);

	// Handshakes.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Fields of the entry read in the previous cycle.
	assign ex    = rbox[BOX_W-1 -: COORD_BITS];
	assign ey    = rbox[3*COORD_BITS-1 -: COORD_BITS];
	assign ew    = rbox[2*COORD_BITS-1 -: COORD_BITS];
	assign eh    = rbox[COORD_BITS-1:0];
	assign rid   = rmeta[META_W-1 -: ID_W];
	assign rmiss = rmeta[MISS_W-1:0];

	// Entry centroid and far edges.
	assign ecx = EXT_W'(ex) + EXT_W'(ew >> 1);
	assign ecy = EXT_W'(ey) + EXT_W'(eh >> 1);
	assign er  = EXT_W'(ex) + EXT_W'(ew);
	assign eb  = EXT_W'(ey) + EXT_W'(eh);

	// Mutual containment test, half-open boxes.
	assign det_in_ent = (dcx_q >= EXT_W'(ex)) && (dcx_q < er) &&
	                    (dcy_q >= EXT_W'(ey)) && (dcy_q < eb);
	assign ent_in_det = (ecx >= EXT_W'(dx_q)) && (ecx < dr_q) &&
	                    (ecy >= EXT_W'(dy_q)) && (ecy < db_q);

	// Miss update for end of frame, saturating.
	assign mnew = (!linked_q[idx_s1] && (rmiss != MISS_MAX)) ? rmiss + 1'b1 : rmiss;

	// Scan pipeline: issue one read a cycle, evaluate it the next cycle.
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < total_q);
	assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !vld_s1;
	assign det_hit    = vld_s1 && (op_q == CMD_DETECT) && det_in_ent && ent_in_det;
	assign keep_hit   = vld_s1 && (op_q == CMD_EOF) && (mnew < miss_limit_q);

	// Final result and listing.
	assign res_load  = (state_q == ST_RESULT) && out_free;
	assign list_load = (state_q == ST_LIST) && rd_ok_q && out_free;
	assign list_end  = (idx_q == total_q - 1'b1);
	assign append    = (op_q == CMD_DETECT) && (match_q == '0) &&
	                   (total_q < CNT_W'(MAX_ENTRIES));
	assign slot_ok   = (32'(slot_q) < 32'(total_q));
	assign idx_next  = list_load ? idx_q + 1'b1 : idx_q;

	// Memory write selection; the sources never overlap in one cycle.
	always_comb begin
		wr_en = '0;
		waddr = idx_s1;
		wbox  = {dx_q, dy_q, dw_q, dh_q};
		wmeta = {rid, {MISS_W{1'b0}}};
		priority if (det_hit) begin
			wr_en.box_we  = 1'b1;
			wr_en.meta_we = 1'b1;
		end else if (keep_hit) begin
			wr_en.box_we  = 1'b1;
			wr_en.meta_we = 1'b1;
			waddr         = keep_q[IDX_W-1:0];
			wbox          = rbox;
			wmeta         = {rid, mnew};
		end else if (res_load && append) begin
			wr_en.box_we  = 1'b1;
			wr_en.meta_we = 1'b1;
			waddr         = total_q[IDX_W-1:0];
			wmeta         = {next_id_q, {MISS_W{1'b0}}};
		end else if (res_load && (op_q == CMD_REFRESH) && slot_ok) begin
			wr_en.box_we  = 1'b1;
			waddr         = IDX_W'(slot_q);
		end
	end

	// Read address: scan cursor, or the listing cursor one word ahead.
	always_comb begin
		if (state_q == ST_LIST) begin
			raddr = idx_next[IDX_W-1:0];
		end else begin
			raddr = idx_q[IDX_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (command)
						CMD_DETECT:  state_d = ST_SCAN;
						CMD_REFRESH: state_d = ST_RESULT;
						CMD_EOF:     state_d = ST_SCAN;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					if ((op_q == CMD_EOF) && (keep_q != '0)) begin
						state_d = ST_LIST;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_RESULT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (list_load && list_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= CMD_DETECT;
			total_q      <= '0;
			idx_q        <= '0;
			keep_q       <= '0;
			match_q      <= '0;
			next_id_q    <= '0;
			miss_limit_q <= MISS_LIMIT_RST;
			linked_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			rd_ok_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				miss_limit_q <= cfg_wr_data;
			end

			vld_s1  <= scan_issue;
			idx_s1  <= idx_q[IDX_W-1:0];
			rd_ok_q <= (state_q == ST_LIST);

			// A new word restarts the cursors.
			if (in_acc) begin
				op_q    <= cmd_t'(command);
				idx_q   <= '0;
				keep_q  <= '0;
				match_q <= '0;
			end

			if (scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end

			if (det_hit) begin
				match_q          <= match_q + 1'b1;
				linked_q[idx_s1] <= 1'b1;
			end

			if (keep_hit) begin
				keep_q <= keep_q + 1'b1;
			end

			// Compaction finished: the survivors form the new table.
			if (scan_done && (op_q == CMD_EOF)) begin
				total_q  <= keep_q;
				linked_q <= '0;
				idx_q    <= '0;
			end

			if (res_load && append) begin
				total_q                       <= total_q + 1'b1;
				next_id_q                     <= next_id_q + 1'b1;
				linked_q[total_q[IDX_W-1:0]] <= 1'b1;
			end

			if (list_load) begin
				idx_q <= idx_next;
			end
		end
	end

	// Detection word capture, with its centroid and far edges.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dx_q   <= box_x;
			dy_q   <= box_y;
			dw_q   <= box_w;
			dh_q   <= box_h;
			dcx_q  <= EXT_W'(box_x) + EXT_W'(box_w >> 1);
			dcy_q  <= EXT_W'(box_y) + EXT_W'(box_h >> 1);
			dr_q   <= EXT_W'(box_x) + EXT_W'(box_w);
			db_q   <= EXT_W'(box_y) + EXT_W'(box_h);
			slot_q <= slot;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || list_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word: either a single final result or one listed entry.
	always_ff @(posedge clk) begin
		if (list_load) begin
			kind_q        <= KIND_ENTRY;
			object_id_q   <= rid;
			match_count_q <= '0;
			out_x_q       <= ex;
			out_y_q       <= ey;
			out_w_q       <= ew;
			out_h_q       <= eh;
			miss_count_q  <= rmiss;
			live_count_q  <= COUNT_W'(total_q);
			last_q        <= list_end;
		end else if (res_load) begin
			object_id_q   <= append ? next_id_q : '0;
			match_count_q <= COUNT_W'(match_q);
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_w_q       <= '0;
			out_h_q       <= '0;
			miss_count_q  <= '0;
			live_count_q  <= append ? COUNT_W'(total_q + 1'b1) : COUNT_W'(total_q);
			last_q        <= 1'b1;
			unique case (op_q)
				CMD_DETECT: begin
					if (match_q != '0) begin
						kind_q <= KIND_MATCHED;
					end else if (append) begin
						kind_q <= KIND_ADDED;
					end else begin
						kind_q <= KIND_DROPPED;
					end
				end
				CMD_REFRESH: begin
					kind_q <= slot_ok ? KIND_REFRESH : KIND_BAD_SLOT;
				end
				CMD_EOF: begin
					kind_q <= KIND_EMPTY;
				end
				default: begin
					kind_q <= KIND_EMPTY;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign object_id   = object_id_q;
	assign match_count = match_count_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_w       = out_w_q;
	assign out_h       = out_h_q;
	assign miss_count  = miss_count_q;
	assign live_count  = live_count_q;
	assign last        = last_q;

endmodule

`default_nettype wire
